/* rtl/core/tfn_pkg.sv */
`default_nettype none
package tfn_pkg;
	localparam int COORD_BITS = 16;
	localparam int NORMAL_FRAC_BITS = 15;
	localparam int NORMAL_W = 16;
	localparam int LANES = 3;

	localparam int DIFF_W = COORD_BITS + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int NMAG_W = 2 * DIFF_W;
	localparam int SQ_W = 2 * NMAG_W;
	localparam int LEN_W = SQ_W + 2;
	localparam int Q_W = 2 * NORMAL_FRAC_BITS + 1;
	localparam int R_W = NORMAL_FRAC_BITS + 1;
	localparam int TW = Q_W + 2;

	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic [NMAG_W-1:0] nmag_t;
	typedef logic [SQ_W-1:0] sq_t;
	typedef logic [LEN_W-1:0] len_t;
	typedef logic [Q_W-1:0] quo_t;
	typedef logic [R_W-1:0] root_t;
endpackage
`default_nettype wire

/* rtl/core/triangle_face_normal.sv */
`default_nettype none
// Absolute unit face normal of one triangle per word. The corners A, B, C come in as signed
// Q8.8; the block forms the exact cross product of B-A and C-B and returns |N_i|/|N| for
// each axis, rounded down, as unsigned Q1.15. A triangle whose corners are collinear or
// coincide returns zero components with degenerate set. The pipeline takes one word in
// every cycle and holds 53 words in flight: five stages for differences, products, cross
// terms, squares and the squared length, then 31 restoring divide stages (one quotient bit
// each) and 16 square root stages (one root bit each), and the output register. A stall on
// the result side halts every stage at once, so tri_ready follows norm_ready combinationally.
module triangle_face_normal (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic tri_valid,
	output logic tri_ready,
	input  wire logic signed [tfn_pkg::COORD_BITS-1:0] a_x,
	input  wire logic signed [tfn_pkg::COORD_BITS-1:0] a_y,
	input  wire logic signed [tfn_pkg::COORD_BITS-1:0] a_z,
	input  wire logic signed [tfn_pkg::COORD_BITS-1:0] b_x,
	input  wire logic signed [tfn_pkg::COORD_BITS-1:0] b_y,
	input  wire logic signed [tfn_pkg::COORD_BITS-1:0] b_z,
	input  wire logic signed [tfn_pkg::COORD_BITS-1:0] c_x,
	input  wire logic signed [tfn_pkg::COORD_BITS-1:0] c_y,
	input  wire logic signed [tfn_pkg::COORD_BITS-1:0] c_z,
	output logic norm_valid,
	input  wire logic norm_ready,
	output logic [tfn_pkg::NORMAL_W-1:0] normal_x,
	output logic [tfn_pkg::NORMAL_W-1:0] normal_y,
	output logic [tfn_pkg::NORMAL_W-1:0] normal_z,
	output logic degenerate
);
	localparam int L = tfn_pkg::LANES;
	localparam int QW = tfn_pkg::Q_W;
	localparam int RW = tfn_pkg::R_W;
	localparam int LW = tfn_pkg::LEN_W;
	localparam int TW = tfn_pkg::TW;

	logic adv;
	assign adv = !norm_valid || norm_ready;
	assign tri_ready = adv;

	tfn_pkg::diff_t p_s1 [L];
	tfn_pkg::diff_t q_s1 [L];
	logic v_s1;
	tfn_pkg::prod_t pa_s2 [L];
	tfn_pkg::prod_t pb_s2 [L];
	logic v_s2;
	tfn_pkg::nmag_t n_s3 [L];
	logic v_s3;
	tfn_pkg::sq_t sq_s4 [L];
	logic v_s4;
	tfn_pkg::sq_t sq_s5 [L];
	tfn_pkg::len_t len_s5;
	logic deg_s5;
	logic v_s5;

	tfn_pkg::len_t div_rem_d [QW][L];
	tfn_pkg::quo_t div_q_d [QW][L];
	tfn_pkg::len_t div_rem_s [QW][L];
	tfn_pkg::quo_t div_q_s [QW][L];
	tfn_pkg::len_t div_len_s [QW];
	logic div_deg_s [QW];
	logic div_v_s [QW];

	tfn_pkg::root_t sqr_r_d [RW][L];
	tfn_pkg::quo_t sqr_rem_d [RW][L];
	tfn_pkg::root_t sqr_r_s [RW][L];
	tfn_pkg::quo_t sqr_rem_s [RW][L];
	logic sqr_deg_s [RW];
	logic sqr_v_s [RW];

	logic signed [tfn_pkg::PROD_W:0] cross_d [L];
	logic signed [tfn_pkg::PROD_W:0] cross_abs [L];

	for (genvar i = 0; i < L; i++) begin : g_cross
		assign cross_d[i] = (tfn_pkg::PROD_W+1)'(pa_s2[i]) - (tfn_pkg::PROD_W+1)'(pb_s2[i]);
		assign cross_abs[i] = cross_d[i][tfn_pkg::PROD_W] ? -cross_d[i] : cross_d[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			for (int j = 0; j < QW; j++) div_v_s[j] <= 1'b0;
			for (int j = 0; j < RW; j++) sqr_v_s[j] <= 1'b0;
			norm_valid <= 1'b0;
		end else if (adv) begin
			v_s1 <= tri_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			div_v_s[0] <= v_s5;
			for (int j = 1; j < QW; j++) div_v_s[j] <= div_v_s[j-1];
			sqr_v_s[0] <= div_v_s[QW-1];
			for (int j = 1; j < RW; j++) sqr_v_s[j] <= sqr_v_s[j-1];
			norm_valid <= sqr_v_s[RW-1];
		end
	end

	for (genvar i = 0; i < L; i++) begin : g_front
		localparam int I1 = (i + 1) % L;
		localparam int I2 = (i + 2) % L;
		always_ff @(posedge clk) begin
			if (adv) begin
				pa_s2[i] <= p_s1[I1] * q_s1[I2];
				pb_s2[i] <= p_s1[I2] * q_s1[I1];
				n_s3[i] <= cross_abs[i][tfn_pkg::NMAG_W-1:0];
				sq_s4[i] <= tfn_pkg::SQ_W'(n_s3[i]) * tfn_pkg::SQ_W'(n_s3[i]);
				sq_s5[i] <= sq_s4[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1[0] <= tfn_pkg::DIFF_W'(b_x) - tfn_pkg::DIFF_W'(a_x);
			p_s1[1] <= tfn_pkg::DIFF_W'(b_y) - tfn_pkg::DIFF_W'(a_y);
			p_s1[2] <= tfn_pkg::DIFF_W'(b_z) - tfn_pkg::DIFF_W'(a_z);
			q_s1[0] <= tfn_pkg::DIFF_W'(c_x) - tfn_pkg::DIFF_W'(b_x);
			q_s1[1] <= tfn_pkg::DIFF_W'(c_y) - tfn_pkg::DIFF_W'(b_y);
			q_s1[2] <= tfn_pkg::DIFF_W'(c_z) - tfn_pkg::DIFF_W'(b_z);
			len_s5 <= LW'(sq_s4[0]) + LW'(sq_s4[1]) + LW'(sq_s4[2]);
			deg_s5 <= (sq_s4[0] == '0) && (sq_s4[1] == '0) && (sq_s4[2] == '0);
		end
	end

	// Long division of sq << 2F by the squared length, one quotient bit per stage.
	for (genvar j = 0; j < QW; j++) begin : g_div
		tfn_pkg::len_t len_in;
		if (j == 0) begin : g_first
			assign len_in = len_s5;
		end else begin : g_next
			assign len_in = div_len_s[j-1];
		end
		for (genvar i = 0; i < L; i++) begin : g_lane
			tfn_pkg::len_t rem_in;
			tfn_pkg::quo_t q_in;
			logic bit_in;
			logic [LW:0] sh;
			logic [LW:0] dif;
			if (j == 0) begin : g_first
				assign rem_in = LW'(sq_s5[i] >> 1);
				assign q_in = '0;
				assign bit_in = sq_s5[i][0];
			end else begin : g_next
				assign rem_in = div_rem_s[j-1][i];
				assign q_in = div_q_s[j-1][i];
				assign bit_in = 1'b0;
			end
			assign sh = {rem_in, bit_in};
			assign dif = sh - {1'b0, len_in};
			assign div_rem_d[j][i] = dif[LW] ? sh[LW-1:0] : dif[LW-1:0];
			assign div_q_d[j][i] = {q_in[QW-2:0], !dif[LW]};
		end
	end

	// Digit-by-digit square root of the quotient, one root bit per stage.
	for (genvar j = 0; j < RW; j++) begin : g_sqr
		localparam int B = RW - 1 - j;
		for (genvar i = 0; i < L; i++) begin : g_lane
			tfn_pkg::root_t r_in;
			tfn_pkg::quo_t rem_in;
			logic [TW-1:0] trial;
			logic [TW:0] dif;
			if (j == 0) begin : g_first
				assign r_in = '0;
				assign rem_in = div_q_s[QW-1][i];
			end else begin : g_next
				assign r_in = sqr_r_s[j-1][i];
				assign rem_in = sqr_rem_s[j-1][i];
			end
			assign trial = (TW'(r_in) << (B + 1)) + (TW'(1) << (2 * B));
			assign dif = (TW+1)'(rem_in) - (TW+1)'(trial);
			assign sqr_rem_d[j][i] = dif[TW] ? rem_in : dif[QW-1:0];
			assign sqr_r_d[j][i] = dif[TW] ? r_in : (r_in | (RW'(1) << B));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < QW; j++) begin
				for (int i = 0; i < L; i++) begin
					div_rem_s[j][i] <= div_rem_d[j][i];
					div_q_s[j][i] <= div_q_d[j][i];
				end
			end
			div_len_s[0] <= len_s5;
			div_deg_s[0] <= deg_s5;
			for (int j = 1; j < QW; j++) begin
				div_len_s[j] <= div_len_s[j-1];
				div_deg_s[j] <= div_deg_s[j-1];
			end
			for (int j = 0; j < RW; j++) begin
				for (int i = 0; i < L; i++) begin
					sqr_r_s[j][i] <= sqr_r_d[j][i];
					sqr_rem_s[j][i] <= sqr_rem_d[j][i];
				end
			end
			sqr_deg_s[0] <= div_deg_s[QW-1];
			for (int j = 1; j < RW; j++) sqr_deg_s[j] <= sqr_deg_s[j-1];
			degenerate <= sqr_deg_s[RW-1];
			normal_x <= sqr_deg_s[RW-1] ? '0 : tfn_pkg::NORMAL_W'(sqr_r_s[RW-1][0]);
			normal_y <= sqr_deg_s[RW-1] ? '0 : tfn_pkg::NORMAL_W'(sqr_r_s[RW-1][1]);
			normal_z <= sqr_deg_s[RW-1] ? '0 : tfn_pkg::NORMAL_W'(sqr_r_s[RW-1][2]);
		end
	end

	localparam logic [tfn_pkg::NORMAL_W-1:0] ONE = tfn_pkg::NORMAL_W'(1) << tfn_pkg::NORMAL_FRAC_BITS;

	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		norm_valid && degenerate |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
		else $error("degenerate word carries a nonzero component");
	a_nondeg_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		norm_valid && !degenerate |-> (normal_x | normal_y | normal_z) != '0)
		else $error("unit normal has all components zero");
	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		norm_valid |-> normal_x <= ONE && normal_y <= ONE && normal_z <= ONE)
		else $error("normal component exceeds one");
endmodule
`default_nettype wire
